@@ hw/rtl/tst_pkg.sv @@
// ----------------------------------------------------------------------------
// tst_pkg: shared types and constants of the ternary search table
// command/status structs between controller and datapath, field widths and
// the reciprocal used for the divide by three
// ----------------------------------------------------------------------------
package tst_pkg;

    localparam int IDX_W  = 10;   // entry_index / position width
    localparam int KEY_W  = 32;   // key width
    localparam int CNT_W  = 11;   // entry_count width
    localparam int RNG_W  = CNT_W + 1;  // signed range bounds, end may reach -1
    localparam int EXT_W  = 17;   // wide enough for any table depth up to 65536

    // floor(d/3) == (d * RECIP_3) >> RECIP_SHIFT for all d below 2048
    localparam int RECIP_3     = 683;
    localparam int RECIP_SHIFT = 11;
    localparam int THIRD_W     = 10;
    localparam int PROD_W      = CNT_W + THIRD_W;

    typedef enum logic {
        KIND_WRITE  = 1'b0,
        KIND_SEARCH = 1'b1
    } t_kind;

    typedef struct packed {
        logic write;      // store key at entry_index
        logic load;       // latch key, open range [0, min(count, depth)-1]
        logic third;      // register (end-start)/3
        logic mid;        // register both split points
        logic step;       // compare and narrow range
        logic cfg_write;  // update entry_count
    } t_cmd;

    typedef struct packed {
        logic empty;      // live range has no entries
        logic hit;        // key equals one of the split entries
    } t_status;

endpackage

@@ hw/rtl/tst_datapath.sv @@
// ----------------------------------------------------------------------------
// tst_datapath: key table, range registers and compare logic
// two-read/one-write table, divide by three through a reciprocal multiply
// ----------------------------------------------------------------------------
module tst_datapath #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tst_pkg::t_cmd                  i_cmd,
    input  logic [tst_pkg::IDX_W-1:0]      i_entry_index,
    input  logic signed [tst_pkg::KEY_W-1:0] i_key_value,
    input  logic [tst_pkg::CNT_W-1:0]      i_cfg_data,
    output tst_pkg::t_status               o_status,
    output logic                           o_found,
    output logic [tst_pkg::IDX_W-1:0]      o_position
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic signed [tst_pkg::KEY_W-1:0] mem [TABLE_DEPTH];

    logic [tst_pkg::CNT_W-1:0]          r_entry_count;
    logic signed [tst_pkg::KEY_W-1:0]   r_key;
    logic signed [tst_pkg::RNG_W-1:0]   r_start;
    logic signed [tst_pkg::RNG_W-1:0]   r_end;
    logic [tst_pkg::THIRD_W-1:0]        r_third;
    logic [tst_pkg::CNT_W-1:0]          r_m1;
    logic [tst_pkg::CNT_W-1:0]          r_m2;
    logic signed [tst_pkg::KEY_W-1:0]   r_rd1;
    logic signed [tst_pkg::KEY_W-1:0]   r_rd2;
    logic                               r_found;
    logic [tst_pkg::IDX_W-1:0]          r_pos;

    logic [tst_pkg::EXT_W-1:0]          wr_ext;
    logic                               wr_in_range;
    logic [tst_pkg::EXT_W-1:0]          cnt_ext;
    logic [tst_pkg::EXT_W-1:0]          cnt_sat;
    logic signed [tst_pkg::RNG_W-1:0]   diff;
    logic [tst_pkg::PROD_W-1:0]         prod;
    logic [tst_pkg::EXT_W-1:0]          m1_ext;
    logic [tst_pkg::EXT_W-1:0]          m2_ext;
    logic                               eq1;
    logic                               eq2;

    assign wr_ext      = tst_pkg::EXT_W'(i_entry_index);
    assign wr_in_range = wr_ext < tst_pkg::EXT_W'(TABLE_DEPTH);

    // entry_count saturates at the table depth
    assign cnt_ext = tst_pkg::EXT_W'(r_entry_count);
    assign cnt_sat = (cnt_ext > tst_pkg::EXT_W'(TABLE_DEPTH)) ?
                     tst_pkg::EXT_W'(TABLE_DEPTH) : cnt_ext;

    assign diff = r_end - r_start;
    assign prod = tst_pkg::PROD_W'(diff[tst_pkg::CNT_W-1:0])
                * tst_pkg::PROD_W'(tst_pkg::RECIP_3);

    assign m1_ext = tst_pkg::EXT_W'(r_m1);
    assign m2_ext = tst_pkg::EXT_W'(r_m2);

    assign eq1 = (r_key == r_rd1);
    assign eq2 = (r_key == r_rd2);

    assign o_status.empty = (r_end < r_start);
    assign o_status.hit   = eq1 | eq2;
    assign o_found        = r_found;
    assign o_position     = r_pos;

    // table: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.write && wr_in_range) begin
            mem[wr_ext[AW-1:0]] <= i_key_value;
        end
        r_rd1 <= mem[m1_ext[AW-1:0]];
        r_rd2 <= mem[m2_ext[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cmd.cfg_write) begin
            r_entry_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key   <= i_key_value;
            r_start <= '0;
            r_end   <= $signed(cnt_sat[tst_pkg::RNG_W-1:0]) - tst_pkg::RNG_W'(1);
            r_found <= 1'b0;
            r_pos   <= '0;
        end
        if (i_cmd.third) begin
            r_third <= prod[tst_pkg::RECIP_SHIFT +: tst_pkg::THIRD_W];
        end
        if (i_cmd.mid) begin
            r_m1 <= r_start[tst_pkg::CNT_W-1:0] + tst_pkg::CNT_W'(r_third);
            r_m2 <= r_end[tst_pkg::CNT_W-1:0] - tst_pkg::CNT_W'(r_third);
        end
        if (i_cmd.step) begin
            if (eq1) begin
                r_found <= 1'b1;
                r_pos   <= r_m1[tst_pkg::IDX_W-1:0];
            end else if (eq2) begin
                r_found <= 1'b1;
                r_pos   <= r_m2[tst_pkg::IDX_W-1:0];
            end else if (r_key < r_rd1) begin
                r_end <= $signed({1'b0, r_m1}) - tst_pkg::RNG_W'(1);
            end else if (r_key > r_rd2) begin
                r_start <= $signed({1'b0, r_m2}) + tst_pkg::RNG_W'(1);
            end else begin
                r_start <= $signed({1'b0, r_m1}) + tst_pkg::RNG_W'(1);
                r_end   <= $signed({1'b0, r_m2}) - tst_pkg::RNG_W'(1);
            end
        end
    end

    // split points never cross
    a_mid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mid |=> (r_m1 <= r_m2))
        else $error("split points out of order");

    // a matching compare always reports found
    a_hit_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && o_status.hit) |=> r_found)
        else $error("hit not recorded");

endmodule

@@ hw/rtl/tst_ctrl.sv @@
// ----------------------------------------------------------------------------
// tst_ctrl: search sequencer
// steps each ternary round through range test, divide, split, table read and compare
// ----------------------------------------------------------------------------
module tst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_kind,
    input  logic              i_cfg_valid,
    input  tst_pkg::t_status  i_status,
    output tst_pkg::t_cmd     o_cmd,
    output logic              o_busy,
    output logic              o_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_THIRD,
        S_MID,
        S_READ,
        S_CMP
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   accept;

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign accept  = i_start && !o_busy;

    always_comb begin
        o_cmd           = '0;
        o_cmd.write     = accept && (tst_pkg::t_kind'(i_kind) == tst_pkg::KIND_WRITE);
        o_cmd.load      = accept && (tst_pkg::t_kind'(i_kind) == tst_pkg::KIND_SEARCH);
        o_cmd.third     = (r_state == S_THIRD);
        o_cmd.mid       = (r_state == S_MID);
        o_cmd.step      = (r_state == S_CMP);
        o_cmd.cfg_write = i_cfg_valid && !o_busy;
    end

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (i_status.empty) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_THIRD;
                end
            end
            S_THIRD: n_state = S_MID;
            S_MID:   n_state = S_READ;
            S_READ:  n_state = S_CMP;
            S_CMP: begin
                if (i_status.hit) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_TEST;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // a result only follows a range test or a compare
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == S_TEST || $past(r_state) == S_CMP))
        else $error("result strobe from wrong state");

    // an accepted search keeps the block busy
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_busy)
        else $error("search accepted without busy");

    // writes and searches never issue together
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.write, o_cmd.load, o_cmd.step}))
        else $error("conflicting commands");

endmodule

@@ hw/rtl/ternary_search_table.sv @@
// ----------------------------------------------------------------------------
// ternary_search_table: sorted key table with iterative ternary search
// write: no result, taken while idle; search: repeated rounds, then one result
// after a hit in the compare or an empty range at the range test
// rounds grow as log3(entry_count), about 7 for 1024 entries
// each round runs the range test, divide, split, table read and compare steps
// one search at a time; busy stays high until its result strobe
// synchronous active-low reset clears entry_count; table contents stay unknown
// ----------------------------------------------------------------------------
module ternary_search_table #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command side: transfer when start is high and busy is low
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_kind,
    input  logic [tst_pkg::IDX_W-1:0]         i_entry_index,
    input  logic signed [tst_pkg::KEY_W-1:0]  i_key_value,
    // entry_count register write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tst_pkg::CNT_W-1:0]         i_cfg_data,
    // result side: one-cycle strobe, no back-pressure
    output logic                              o_valid,
    output logic                              o_found,
    output logic [tst_pkg::IDX_W-1:0]         o_position
);

    tst_pkg::t_cmd    cmd;
    tst_pkg::t_status status;

    // config is taken whenever no search is running
    assign o_cfg_ready = !busy;

    // sequencer: accepts commands, walks the rounds, raises the result strobe
    tst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_kind      (i_kind),
        .i_cfg_valid (i_cfg_valid),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_busy      (busy),
        .o_valid     (o_valid)
    );

    // table memory, range bounds and comparators
    tst_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_entry_index (i_entry_index),
        .i_key_value   (i_key_value),
        .i_cfg_data    (i_cfg_data),
        .o_status      (status),
        .o_found       (o_found),
        .o_position    (o_position)
    );

endmodule

@@ tb/ternary_search_table_checker.sv @@
// ----------------------------------------------------------------------------
// ternary_search_table_checker: result predictor and scoreboard
// watches the command, config and result channels of the search table, keeps
// its own copy of the key table and entry_count, works out the expected
// answer of every accepted search and compares results in order
// ----------------------------------------------------------------------------
module ternary_search_table_checker #(
    parameter int TABLE_DEPTH = 1024,
    parameter int PRINT_CAP   = 40
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic                              i_kind,
    input  logic [tst_pkg::IDX_W-1:0]         i_entry_index,
    input  logic signed [tst_pkg::KEY_W-1:0]  i_key_value,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [tst_pkg::CNT_W-1:0]         i_cfg_data,
    input  logic                              i_res_valid,
    input  logic                              i_found,
    input  logic [tst_pkg::IDX_W-1:0]         i_position,
    output int                                o_pending,
    output int                                o_fail_count,
    output int                                o_hit_count
);

    typedef struct packed {
        logic                      found;
        logic [tst_pkg::IDX_W-1:0] position;
    } t_lookup;

    logic signed [tst_pkg::KEY_W-1:0] key_store [TABLE_DEPTH];
    logic [tst_pkg::CNT_W-1:0]        entry_limit;
    t_lookup                          lookup_q [$];
    int                               mismatches = 0;
    int                               hits = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_CAP) begin
            $display("mismatch at %0t: %s, got %0d, want %0d", $time, what, got, want);
        end
        mismatches++;
    endtask

    // iterative ternary search over entries 0 .. min(count, depth)-1
    function automatic t_lookup ternary_lookup(
        input logic signed [tst_pkg::KEY_W-1:0] key);
        t_lookup                          r;
        int                               lo;
        int                               hi;
        int                               third;
        int                               m1;
        int                               m2;
        logic signed [tst_pkg::KEY_W-1:0] v1;
        logic signed [tst_pkg::KEY_W-1:0] v2;
        bit                               done;
        r    = '0;
        lo   = 0;
        hi   = (int'(entry_limit) > TABLE_DEPTH) ? TABLE_DEPTH - 1 : int'(entry_limit) - 1;
        done = 1'b0;
        while (!done && hi >= lo) begin
            third = (hi - lo) / 3;
            m1    = lo + third;
            m2    = hi - third;
            v1    = key_store[m1];
            v2    = key_store[m2];
            if (key == v1) begin
                r.found    = 1'b1;
                r.position = m1[tst_pkg::IDX_W-1:0];
                done       = 1'b1;
            end else if (key == v2) begin
                r.found    = 1'b1;
                r.position = m2[tst_pkg::IDX_W-1:0];
                done       = 1'b1;
            end else if (key < v1) begin
                hi = m1 - 1;
            end else if (key > v2) begin
                lo = m2 + 1;
            end else begin
                lo = m1 + 1;
                hi = m2 - 1;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_lookup want;
        if (!i_rst_n) begin
            lookup_q.delete();
            entry_limit = '0;
        end else begin
            if (i_res_valid === 1'b1) begin
                if (lookup_q.size() == 0) begin
                    report_mismatch("result with no search waiting", i_position, 0);
                end else begin
                    want = lookup_q.pop_front();
                    if (i_found !== want.found) begin
                        report_mismatch("found", i_found, want.found);
                    end
                    if (i_position !== want.position) begin
                        report_mismatch("position", i_position, want.position);
                    end
                    if (want.found) begin
                        hits++;
                    end
                end
            end
            // a search taken together with a count write still sees the old count
            if (i_start && !i_busy) begin
                if (tst_pkg::t_kind'(i_kind) == tst_pkg::KIND_SEARCH) begin
                    lookup_q.push_back(ternary_lookup(i_key_value));
                end else if (int'(i_entry_index) < TABLE_DEPTH) begin
                    key_store[i_entry_index] = i_key_value;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                entry_limit = i_cfg_data;
            end
        end
        o_pending    <= lookup_q.size();
        o_fail_count <= mismatches;
        o_hit_count  <= hits;
    end

endmodule

@@ tb/ternary_search_table_tb.sv @@
// ----------------------------------------------------------------------------
// ternary_search_table_tb: stimulus and verdict for the ternary search table
// fills the key table with sorted keys, steps entry_count through empty,
// tiny, mid, full and saturated sizes, and fires mixed writes and searches
// with random idle bursts; a separate checker predicts and compares results
// ----------------------------------------------------------------------------
module ternary_search_table_tb;

    localparam int DEPTH         = 1024;
    localparam int RESET_CYCLES  = 9;
    localparam int GAP_MAX       = 18;
    localparam int PHASE_ITEMS   = 22;
    // tables up to this size get fresh sorted contents on every phase
    localparam int FRESH_FILL_MAX = 8;
    // a trailing write can still be in flight when the last result is seen
    localparam int SETTLE_CYCLES = 48;
    localparam int TAIL_CYCLES   = 64;
    // the idle limit lies far beyond a full-table search or the longest sender gap,
    // so it is far beyond any correct stretch
    localparam int IDLE_LIMIT    = 2000;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             start = 1'b0;
    logic                             busy;
    logic                             i_kind = 1'b0;
    logic [tst_pkg::IDX_W-1:0]        i_entry_index = '0;
    logic signed [tst_pkg::KEY_W-1:0] i_key_value = '0;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [tst_pkg::CNT_W-1:0]        i_cfg_data = '0;
    logic                             o_valid;
    logic                             o_found;
    logic [tst_pkg::IDX_W-1:0]        o_position;

    int pending;
    int fail_count;
    int hit_count;
    int idle_cycles = 0;

    // stimulus-side mirror of the table, used only to pick meaningful keys
    int shadow_key [DEPTH];
    bit written [DEPTH];
    bit gaps_on = 1'b0;
    int search_total = 0;
    int write_total = 0;
    int cfg_total = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    ternary_search_table #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_entry_index (i_entry_index),
        .i_key_value   (i_key_value),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_found       (o_found),
        .o_position    (o_position)
    );

    ternary_search_table_checker #(
        .TABLE_DEPTH(DEPTH)
    ) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_kind        (i_kind),
        .i_entry_index (i_entry_index),
        .i_key_value   (i_key_value),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_res_valid   (o_valid),
        .i_found       (o_found),
        .i_position    (o_position),
        .o_pending     (pending),
        .o_fail_count  (fail_count),
        .o_hit_count   (hit_count)
    );

    // watchdog: any command, config or result transfer resets the count
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("no transfer for %0d cycles, giving up", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one command transfer; start stays high into the next item when no gap
    // is drawn, so back-to-back commands queue up behind busy
    task automatic send_item(input tst_pkg::t_kind kind,
                             input logic [tst_pkg::IDX_W-1:0] idx, input int key);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(1, GAP_MAX) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start         <= 1'b1;
        i_kind        <= kind;
        i_entry_index <= idx;
        i_key_value   <= key;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (kind == tst_pkg::KIND_WRITE) begin
            shadow_key[idx] = key;
            written[idx]    = 1'b1;
            write_total++;
        end else begin
            search_total++;
        end
    endtask

    task automatic search_key(input int key);
        send_item(tst_pkg::KIND_SEARCH, tst_pkg::IDX_W'($urandom), key);
    endtask

    // hold the sender off until every outstanding search has answered
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // entry_count only changes while the block is idle
    task automatic write_count(input int count);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= tst_pkg::CNT_W'(count);
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_total++;
    endtask

    // one setting of entry_count: sorted fill where needed, then a random mix
    // of mostly well-formed searches with some order-keeping and noise writes
    task automatic run_phase(input int count, input int n_items);
        int  vals [$];
        int  eff;
        int  idx;
        int  key;
        int  pick;
        bit  refill;
        bit  narrow;
        eff    = (count > DEPTH) ? DEPTH : count;
        refill = (eff <= FRESH_FILL_MAX);
        for (int i = 0; i < eff; i++) begin
            if (!written[i]) begin
                refill = 1'b1;
            end
        end
        if (refill) begin
            // narrow values give duplicates and adjacent keys
            narrow = ($urandom_range(0, 2) == 0);
            for (int i = 0; i < eff; i++) begin
                vals.push_back(narrow ? int'($urandom_range(0, 2 * eff + 4)) - eff
                                      : int'($urandom));
            end
            vals.sort();
            for (int i = 0; i < eff; i++) begin
                send_item(tst_pkg::KIND_WRITE, tst_pkg::IDX_W'(i), vals[i]);
            end
        end
        write_count(count);
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15 && eff > 0) begin
                // rewrite with own or neighbor value: order is kept
                idx = $urandom_range(0, eff - 1);
                case ($urandom_range(0, 2))
                    0: key = shadow_key[idx];
                    1: key = (idx > 0) ? shadow_key[idx - 1] : shadow_key[idx];
                    default: key = (idx + 1 < eff) ? shadow_key[idx + 1] : shadow_key[idx];
                endcase
                send_item(tst_pkg::KIND_WRITE, tst_pkg::IDX_W'(idx), key);
            end else if (pick < 22) begin
                // noise: any index, any value, may break the ordering
                send_item(tst_pkg::KIND_WRITE, tst_pkg::IDX_W'($urandom), int'($urandom));
            end else begin
                pick = $urandom_range(0, 99);
                idx  = (eff > 0) ? $urandom_range(0, eff - 1) : 0;
                if (pick < 55) begin
                    key = shadow_key[idx];
                end else if (pick < 72) begin
                    key = shadow_key[idx] + (($urandom_range(0, 1) == 1) ? 1 : -1);
                end else if (pick < 82) begin
                    case ($urandom_range(0, 3))
                        0: key = int'(32'h8000_0000);
                        1: key = int'(32'h7fff_ffff);
                        2: key = 0;
                        default: key = -1;
                    endcase
                end else begin
                    key = int'($urandom);
                end
                search_key(key);
            end
            if ($urandom_range(0, 99) == 0) begin
                drain_results();
            end
        end
    endtask

    initial begin : stimulus
        int seed_keys [8];
        int plan [12];
        seed_keys = '{int'(32'h8000_0000), -1000, -1, 0, 1, 77,
                      int'(32'h4000_0000), int'(32'h7fff_ffff)};
        // the full table is filled once; later counts search its sorted prefix
        plan = '{1, 2, 3, 4, 7, DEPTH, 27, 81, 150, $urandom_range(9, 60), 2047, DEPTH + 1};

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty range straight out of reset
        search_key(0);

        // sorted seed table with both key extremes
        for (int i = 0; i < 8; i++) begin
            send_item(tst_pkg::KIND_WRITE, tst_pkg::IDX_W'(i), seed_keys[i]);
        end
        write_count(8);
        search_key(seed_keys[0]);
        search_key(seed_keys[7]);
        search_key(0);
        search_key(77);
        search_key(-1);
        search_key(5);

        // single entry: hit at 0 and a miss
        write_count(1);
        search_key(seed_keys[0]);
        search_key(0);

        // unsorted table: the search may walk past a present key
        send_item(tst_pkg::KIND_WRITE, tst_pkg::IDX_W'(3), int'(32'h7fff_ffff));
        write_count(8);
        search_key(0);
        search_key(int'(32'h7fff_ffff));

        // explicit zero count
        write_count(0);
        search_key(int'(32'h8000_0000));

        gaps_on = 1'b1;
        foreach (plan[p]) begin
            run_phase(plan[p], PHASE_ITEMS);
        end

        // closing stretch without idle bursts
        gaps_on = 1'b0;
        run_phase($urandom_range(9, 40), PHASE_ITEMS);

        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("covered %0d searches (%0d found) and %0d table writes",
                 search_total, hit_count, write_total);
        $display("over %0d entry_count settings: empty, small, full table and saturated",
                 cfg_total);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/tst_pkg.sv
hw/rtl/tst_datapath.sv
hw/rtl/tst_ctrl.sv
hw/rtl/ternary_search_table.sv
tb/ternary_search_table_checker.sv
tb/ternary_search_table_tb.sv
